// File: rtl/twodm_pkg.sv
`default_nettype none

package twodm_pkg;

    localparam int HEADING_W   = 9;
    localparam int SPEED_FIELD_W = 12;
    localparam int MAG_W       = 12;
    localparam int SPEED_BITS  = 12;
    localparam int SPEED_W     = (SPEED_BITS < SPEED_FIELD_W) ? SPEED_BITS : SPEED_FIELD_W;

    localparam int FULL_TURN   = 360;
    localparam int HALF_TURN   = 180;
    localparam int QUARTER     = 90;
    localparam int THREE_QTR   = 270;

    localparam int TRIG_W      = 16;
    localparam int SIN_IDX_W   = 7;
    localparam int SIN_DEPTH   = 1 << SIN_IDX_W;

    localparam int HALF_ROOT3_Q16 = 56756;
    localparam int COEF_W      = 16;

    localparam int FRAC_SHIFT  = 31;
    localparam int PROD_W      = SPEED_W + TRIG_W;
    localparam int SIN_TERM_W  = PROD_W + COEF_W;
    localparam int SUM_W       = SIN_TERM_W + 2;
    localparam int A_MAG_W     = PROD_W - 15;
    localparam int WIDE_MAG_W  = SUM_W - FRAC_SHIFT;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam int NSTAGE      = 7;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
    localparam logic [63:0] UNIT_Q15 = 64'd32768;
    localparam int TAYLOR_TERMS = 6;

    typedef logic [63:0] taylor_div_t [0:TAYLOR_TERMS-1];
    localparam taylor_div_t TAYLOR_DIV = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef logic [TRIG_W-1:0] sin_tab_t [0:SIN_DEPTH-1];

    typedef struct packed {
        logic [HEADING_W-1:0]     heading_deg;
        logic [SPEED_FIELD_W-1:0] drive_speed;
    } cmd_word_t;

    typedef struct packed {
        logic             wheel_a_ccw;
        logic [MAG_W-1:0] wheel_a_mag;
        logic             wheel_a_en;
        logic             wheel_b_ccw;
        logic [MAG_W-1:0] wheel_b_mag;
        logic             wheel_b_en;
        logic             wheel_c_ccw;
        logic [MAG_W-1:0] wheel_c_mag;
        logic             wheel_c_en;
    } wheel_word_t;

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        int          d;
        int          k;
        for (d = 0; d < SIN_DEPTH; d++)
        begin
            tab[d] = '0;
        end
        for (d = 0; d <= QUARTER; d++)
        begin
            x  = (64'(d) * PI_Q30 + 64'(QUARTER)) / 64'(HALF_TURN);
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (k = 0; k < TAYLOR_TERMS; k++)
            begin
                t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[k];
            end
            s = (x * t) >> 30;
            q = (s + (64'd1 << 14)) >> 15;
            if (q > UNIT_Q15)
            begin
                q = UNIT_Q15;
            end
            tab[d] = q[TRIG_W-1:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

`default_nettype wire

// File: rtl/three_wheel_omni_drive_mixer_unit.sv
// Channel | Dir | Handshake                 | Word
// cmd     | in  | cmd_valid / cmd_ready     | cmd_word_t   (heading_deg, drive_speed)
// wheel   | out | wheel_valid / wheel_ready | wheel_word_t (ccw, mag, en per wheel)
//
// One word per cycle sustained while the output is not stalled; there are seven register
// stages (fold, table read, two multiply stages, sign, add, magnitude).
// The whole pipeline advances together when the output is free or being taken.
// A stall freezes every stage; bubbles travel as cleared valid bits.
// Reset clears the valid bits only.
`default_nettype none

module three_wheel_omni_drive_mixer_unit
    import twodm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire cmd_word_t   cmd,
    output logic             wheel_valid,
    input  wire logic        wheel_ready,
    output wheel_word_t      wheel
);

    logic                   advance;
    logic [NSTAGE-1:0]      vld_reg;
    logic [NSTAGE-1:0]      vld_next;

    logic [HEADING_W-1:0]   deg;
    logic [SIN_IDX_W-1:0]   s_idx_next;
    logic [SIN_IDX_W-1:0]   c_idx_next;
    logic                   s_neg_next;
    logic                   c_neg_next;

    logic [SIN_IDX_W-1:0]   s_idx_reg;
    logic [SIN_IDX_W-1:0]   c_idx_reg;
    logic [1:0]             neg1_reg;
    logic [SPEED_W-1:0]     spd1_reg;

    logic [TRIG_W-1:0]      smag2_reg;
    logic [TRIG_W-1:0]      cmag2_reg;
    logic [1:0]             neg2_reg;
    logic [SPEED_W-1:0]     spd2_reg;

    logic [PROD_W-1:0]      ps3_reg;
    logic [PROD_W-1:0]      pc3_reg;
    logic [1:0]             neg3_reg;

    logic [SIN_TERM_W-1:0]  ts4_reg;
    logic [PROD_W-1:0]      pc4_reg;
    logic [1:0]             neg4_reg;

    logic signed [SUM_W-1:0] ts5_reg;
    logic signed [SUM_W-1:0] tc5_reg;
    logic [MAG_W-1:0]       amag5_reg;
    logic                   aneg5_reg;

    logic signed [SUM_W-1:0] b6_reg;
    logic signed [SUM_W-1:0] c6_reg;
    logic [MAG_W-1:0]       amag6_reg;
    logic                   aneg6_reg;

    logic [A_MAG_W-1:0]     amag_wide;
    logic [MAG_W-1:0]       amag_next;
    logic [SUM_W-1:0]       babs;
    logic [SUM_W-1:0]       cabs;
    logic [WIDE_MAG_W-1:0]  bmag_wide;
    logic [WIDE_MAG_W-1:0]  cmag_wide;
    logic [MAG_W-1:0]       bmag;
    logic [MAG_W-1:0]       cmag;
    wheel_word_t            wheel_next;
    wheel_word_t            wheel_reg;

    assign advance     = !vld_reg[NSTAGE-1] || wheel_ready;
    assign cmd_ready   = advance;
    assign wheel_valid = vld_reg[NSTAGE-1];
    assign wheel       = wheel_reg;
    assign vld_next    = {vld_reg[NSTAGE-2:0], cmd_valid};

    // fold heading into a quadrant
    always_comb
    begin
        deg = (cmd.heading_deg >= HEADING_W'(FULL_TURN))
            ? cmd.heading_deg - HEADING_W'(FULL_TURN) : cmd.heading_deg;
        if (deg <= HEADING_W'(QUARTER))
        begin
            s_idx_next = SIN_IDX_W'(deg);
            c_idx_next = SIN_IDX_W'(HEADING_W'(QUARTER) - deg);
            s_neg_next = 1'b0;
            c_neg_next = 1'b0;
        end
        else if (deg <= HEADING_W'(HALF_TURN))
        begin
            s_idx_next = SIN_IDX_W'(HEADING_W'(HALF_TURN) - deg);
            c_idx_next = SIN_IDX_W'(deg - HEADING_W'(QUARTER));
            s_neg_next = 1'b0;
            c_neg_next = 1'b1;
        end
        else if (deg <= HEADING_W'(THREE_QTR))
        begin
            s_idx_next = SIN_IDX_W'(deg - HEADING_W'(HALF_TURN));
            c_idx_next = SIN_IDX_W'(HEADING_W'(THREE_QTR) - deg);
            s_neg_next = 1'b1;
            c_neg_next = 1'b1;
        end
        else
        begin
            s_idx_next = SIN_IDX_W'(HEADING_W'(FULL_TURN) - deg);
            c_idx_next = SIN_IDX_W'(deg - HEADING_W'(THREE_QTR));
            s_neg_next = 1'b1;
            c_neg_next = 1'b0;
        end
    end

    // wheel A, then magnitudes of B and C
    always_comb
    begin
        amag_wide = pc4_reg[PROD_W-1:15];
        amag_next = (amag_wide > A_MAG_W'(MAG_MAX)) ? MAG_MAX : amag_wide[MAG_W-1:0];

        babs = b6_reg[SUM_W-1] ? SUM_W'(-b6_reg) : SUM_W'(b6_reg);
        cabs = c6_reg[SUM_W-1] ? SUM_W'(-c6_reg) : SUM_W'(c6_reg);
        bmag_wide = babs[SUM_W-1:FRAC_SHIFT];
        cmag_wide = cabs[SUM_W-1:FRAC_SHIFT];
        bmag = (bmag_wide > WIDE_MAG_W'(MAG_MAX)) ? MAG_MAX : bmag_wide[MAG_W-1:0];
        cmag = (cmag_wide > WIDE_MAG_W'(MAG_MAX)) ? MAG_MAX : cmag_wide[MAG_W-1:0];

        wheel_next.wheel_a_mag = amag6_reg;
        wheel_next.wheel_a_en  = amag6_reg != '0;
        wheel_next.wheel_a_ccw = aneg6_reg && (amag6_reg != '0);
        wheel_next.wheel_b_mag = bmag;
        wheel_next.wheel_b_en  = bmag != '0;
        wheel_next.wheel_b_ccw = !b6_reg[SUM_W-1] && (bmag != '0);
        wheel_next.wheel_c_mag = cmag;
        wheel_next.wheel_c_en  = cmag != '0;
        wheel_next.wheel_c_ccw = !c6_reg[SUM_W-1] && (cmag != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s_idx_reg <= s_idx_next;
            c_idx_reg <= c_idx_next;
            neg1_reg  <= {s_neg_next, c_neg_next};
            spd1_reg  <= cmd.drive_speed[SPEED_W-1:0];

            smag2_reg <= SIN_TAB[s_idx_reg];
            cmag2_reg <= SIN_TAB[c_idx_reg];
            neg2_reg  <= neg1_reg;
            spd2_reg  <= spd1_reg;

            ps3_reg   <= PROD_W'(spd2_reg) * PROD_W'(smag2_reg);
            pc3_reg   <= PROD_W'(spd2_reg) * PROD_W'(cmag2_reg);
            neg3_reg  <= neg2_reg;

            ts4_reg   <= SIN_TERM_W'(ps3_reg) * SIN_TERM_W'(HALF_ROOT3_Q16);
            pc4_reg   <= pc3_reg;
            neg4_reg  <= neg3_reg;

            ts5_reg   <= neg4_reg[1] ? -$signed(SUM_W'(ts4_reg)) : $signed(SUM_W'(ts4_reg));
            tc5_reg   <= neg4_reg[0] ? -$signed(SUM_W'(pc4_reg) << 15)
                                     : $signed(SUM_W'(pc4_reg) << 15);
            amag5_reg <= amag_next;
            aneg5_reg <= neg4_reg[0];

            b6_reg    <= tc5_reg - ts5_reg;
            c6_reg    <= tc5_reg + ts5_reg;
            amag6_reg <= amag5_reg;
            aneg6_reg <= aneg5_reg;

            wheel_reg <= wheel_next;
        end
    end

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (s_idx_reg <= SIN_IDX_W'(QUARTER)) && (c_idx_reg <= SIN_IDX_W'(QUARTER)))
        else $error("table index out of quadrant");

    a_ccw_en: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid |-> (!wheel.wheel_a_ccw || wheel.wheel_a_en)
                     && (!wheel.wheel_b_ccw || wheel.wheel_b_en)
                     && (!wheel.wheel_c_ccw || wheel.wheel_c_en))
        else $error("ccw set on a stopped wheel");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import twodm_pkg::*;

    localparam int RANDOM_CMDS = 1350;
    localparam int QUIET_TAIL  = 150;
    localparam int SETTLE_CYC  = 16;
    localparam int DEG_FULL    = 360;
    localparam int DEG_HALF    = 180;
    localparam int DEG_QTR     = 90;
    localparam int DEG_3QTR    = 270;

    localparam logic [63:0] ANG_PI_Q30 = 64'd3373259426;
    localparam logic [63:0] ANG_ONE    = 64'd1 << 30;
    localparam logic [63:0] SIN_FULL   = 64'd32768;
    localparam longint      K_HALF     = 32768;
    localparam longint      K_ROOT3_2  = 56756;
    localparam longint      MAG_LIMIT  = 4095;

    typedef struct packed {
        logic      drain_first;
        cmd_word_t word;
    } queued_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_word_t   cmd = '0;
    logic        wheel_valid;
    logic        wheel_ready = 1'b0;
    wheel_word_t wheel;

    queued_cmd_t cmd_backlog[$];
    wheel_word_t wheel_expected[$];

    int cmd_gap;
    int ready_stall;
    int cmds_sent;
    int words_checked;
    int words_at_rest;
    int directed_cmds;
    int fail_count;

    three_wheel_omni_drive_mixer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .wheel_valid (wheel_valid),
        .wheel_ready (wheel_ready),
        .wheel       (wheel)
    );

    always #6 clk = ~clk;

    // sine of 0..90 degrees, unsigned Q1.15 with 1.0 = 32768
    function automatic longint sine_deg(input int unsigned deg);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] series;
        logic [63:0] rounded;
        int          n;
        ang    = (64'(deg) * ANG_PI_Q30 + 64'd90) / 64'd180;
        ang_sq = (ang * ang) >> 30;
        series = ANG_ONE;
        for (n = 13; n >= 3; n -= 2)
        begin
            series = ANG_ONE - ((ang_sq * series) >> 30) / 64'(n * (n - 1));
        end
        rounded = (((ang * series) >> 30) + (64'd1 << 14)) >> 15;
        if (rounded > SIN_FULL)
        begin
            rounded = SIN_FULL;
        end
        return longint'(rounded);
    endfunction

    // {ccw, mag, en} of one wheel from its Q.31 velocity
    function automatic logic [MAG_W+1:0] wheel_drive(input longint vel);
        longint          vmag;
        logic [MAG_W-1:0] mag;
        vmag = (vel < 0) ? -vel : vel;
        vmag = vmag >>> 31;
        mag  = (vmag > MAG_LIMIT) ? MAG_W'(MAG_LIMIT) : MAG_W'(vmag);
        return {(vel > 0) && (mag != 0), mag, mag != 0};
    endfunction

    function automatic wheel_word_t mix_wheels(input cmd_word_t c);
        int unsigned deg;
        longint      spd;
        longint      sn;
        longint      cs;
        deg = int'(c.heading_deg) % DEG_FULL;
        spd = longint'(c.drive_speed) & ((longint'(1) << SPEED_BITS) - 1);
        if (deg <= DEG_QTR)
        begin
            sn = sine_deg(deg);
            cs = sine_deg(DEG_QTR - deg);
        end
        else if (deg <= DEG_HALF)
        begin
            sn = sine_deg(DEG_HALF - deg);
            cs = -sine_deg(deg - DEG_QTR);
        end
        else if (deg <= DEG_3QTR)
        begin
            sn = -sine_deg(deg - DEG_HALF);
            cs = -sine_deg(DEG_3QTR - deg);
        end
        else
        begin
            sn = -sine_deg(DEG_FULL - deg);
            cs = sine_deg(deg - DEG_3QTR);
        end
        return wheel_word_t'({wheel_drive(-(spd * cs * 65536)),
                              wheel_drive(spd * (cs * K_HALF - sn * K_ROOT3_2)),
                              wheel_drive(spd * (cs * K_HALF + sn * K_ROOT3_2))});
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_cmd(input int unsigned hdg, input int unsigned spd,
                             input logic drain);
        queued_cmd_t q;
        q.drain_first      = drain;
        q.word.heading_deg = HEADING_W'(hdg);
        q.word.drive_speed = SPEED_FIELD_W'(spd);
        cmd_backlog.push_back(q);
    endtask

    function automatic bit idle_phase();
        return (cmd_backlog.size() >= QUIET_TAIL) && (((cmds_sent / 120) % 3) != 0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            cmd_gap = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                wheel_expected.push_back(mix_wheels(cmd));
                cmds_sent++;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog.size() == 0)
                begin
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog[0].drain_first && wheel_expected.size() != 0)
                begin
                    cmd_valid <= 1'b0;
                end
                else if (idle_phase() && $urandom_range(0, 4) == 0)
                begin
                    cmd_gap = $urandom_range(0, 6);
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    cmd       <= cmd_backlog[0].word;
                    cmd_valid <= 1'b1;
                    void'(cmd_backlog.pop_front());
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        wheel_word_t want;
        if (!rst_n)
        begin
            wheel_ready <= 1'b0;
            ready_stall = 0;
        end
        else
        begin
            if (wheel_valid && wheel_ready)
            begin
                if (wheel_expected.size() == 0)
                begin
                    $error("wheel word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = wheel_expected.pop_front();
                    words_checked++;
                    if (!want.wheel_a_en || !want.wheel_b_en || !want.wheel_c_en)
                    begin
                        words_at_rest++;
                    end
                    check_field("wheel_a_ccw", want.wheel_a_ccw, wheel.wheel_a_ccw);
                    check_field("wheel_a_mag", want.wheel_a_mag, wheel.wheel_a_mag);
                    check_field("wheel_a_en",  want.wheel_a_en,  wheel.wheel_a_en);
                    check_field("wheel_b_ccw", want.wheel_b_ccw, wheel.wheel_b_ccw);
                    check_field("wheel_b_mag", want.wheel_b_mag, wheel.wheel_b_mag);
                    check_field("wheel_b_en",  want.wheel_b_en,  wheel.wheel_b_en);
                    check_field("wheel_c_ccw", want.wheel_c_ccw, wheel.wheel_c_ccw);
                    check_field("wheel_c_mag", want.wheel_c_mag, wheel.wheel_c_mag);
                    check_field("wheel_c_en",  want.wheel_c_en,  wheel.wheel_c_en);
                end
            end
            if (ready_stall > 0)
            begin
                ready_stall--;
                wheel_ready <= 1'b0;
            end
            else if (idle_phase() && $urandom_range(0, 5) == 0)
            begin
                ready_stall = $urandom_range(0, 6);
                wheel_ready <= 1'b0;
            end
            else
            begin
                wheel_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int unsigned hdg;
        int unsigned spd;
        int          i;
        rst_n = 1'b0;

        queue_cmd(0, 4095, 1'b0);
        queue_cmd(90, 4095, 1'b0);
        queue_cmd(180, 4095, 1'b0);
        queue_cmd(270, 4095, 1'b0);
        queue_cmd(359, 4095, 1'b0);
        queue_cmd(360, 4095, 1'b0);
        queue_cmd(511, 4095, 1'b0);
        queue_cmd(400, 1234, 1'b0);
        queue_cmd(45, 2048, 1'b0);
        queue_cmd(135, 2048, 1'b0);
        queue_cmd(225, 2048, 1'b0);
        queue_cmd(315, 2048, 1'b0);
        queue_cmd(30, 1, 1'b0);
        queue_cmd(60, 1, 1'b0);
        queue_cmd(120, 3, 1'b0);
        queue_cmd(150, 1, 1'b0);
        queue_cmd(0, 0, 1'b0);
        queue_cmd(1, 1, 1'b0);
        queue_cmd(89, 4095, 1'b0);
        queue_cmd(91, 4095, 1'b0);
        queue_cmd(179, 1000, 1'b0);
        queue_cmd(181, 1000, 1'b0);
        queue_cmd(269, 4095, 1'b0);
        queue_cmd(271, 4095, 1'b0);
        queue_cmd(300, 2, 1'b0);
        directed_cmds = cmd_backlog.size();

        for (i = 0; i < RANDOM_CMDS; i++)
        begin
            case ($urandom_range(0, 9))
                0: hdg = $urandom_range(DEG_FULL, (1 << HEADING_W) - 1);
                1: hdg = DEG_QTR * $urandom_range(0, 4) + $urandom_range(0, 2) - 1;
                default: hdg = $urandom_range(0, DEG_FULL - 1);
            endcase
            hdg = hdg & ((1 << HEADING_W) - 1);
            case ($urandom_range(0, 9))
                0: spd = $urandom_range(0, 3);
                1: spd = (1 << SPEED_FIELD_W) - 1 - $urandom_range(0, 3);
                2: spd = $urandom_range(0, 63);
                default: spd = $urandom_range(0, (1 << SPEED_FIELD_W) - 1);
            endcase
            queue_cmd(hdg, spd, (i % 300) == 0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || cmd_valid || wheel_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);

        $display("%0d commands driven (%0d directed), %0d wheel words checked",
                 cmds_sent, directed_cmds, words_checked);
        $display("%0d words had at least one wheel at rest", words_at_rest);
        if (fail_count == 0 && wheel_expected.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/twodm_pkg.sv
rtl/three_wheel_omni_drive_mixer_unit.sv
tb/sv/tb_top.sv
